>>> hdl/euler_to_quaternion_defines.svh
// ---------------------------------------------------------------------------
// euler_to_quaternion assertion macros
// Shared property wrappers, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define E2Q_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define E2Q_CHECK_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hdl/e2q_pkg.sv
// ---------------------------------------------------------------------------
// e2q_pkg
// Constants, tables and types shared by the Euler to quaternion pipeline.
// ---------------------------------------------------------------------------
package e2q_pkg;

    // polynomial steps per series
    localparam int STEPS = 6;
    localparam int unsigned SIN_DEN [STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DEN [STEPS] = '{132, 90, 56, 30, 12, 2};

    // pi/2 and pi/4 in units of 2^-60 rad
    localparam logic signed [63:0] RED_P = 64'sh1921FB54442D1847;
    localparam logic signed [63:0] RED_E = 64'sh0C90FDAA22168C23;

    localparam logic [32:0] ONE_Q31 = 33'h0_8000_0000;

    // sincos: 4 reduce, abs, round, square, 3 per step, sine product, quadrant
    localparam int SC_LAT = 4 + 3 + 3 * STEPS + 2;
    localparam int QM_LAT = 2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [4:0] SEQ_EXT_FIRST = 5'd12;
    localparam logic [4:0] SEQ_LAST      = 5'd23;

    // {first, second, third} axis of each sequence
    localparam logic [5:0] SEQ_AXES [24] = '{
        {AX_X, AX_Y, AX_Z}, {AX_X, AX_Z, AX_Y}, {AX_Y, AX_X, AX_Z},
        {AX_Y, AX_Z, AX_X}, {AX_Z, AX_X, AX_Y}, {AX_Z, AX_Y, AX_X},
        {AX_Y, AX_X, AX_Y}, {AX_Z, AX_X, AX_Z}, {AX_X, AX_Y, AX_X},
        {AX_Z, AX_Y, AX_Z}, {AX_Y, AX_Z, AX_Y}, {AX_X, AX_Z, AX_X},
        {AX_X, AX_Y, AX_Z}, {AX_X, AX_Z, AX_Y}, {AX_Y, AX_X, AX_Z},
        {AX_Y, AX_Z, AX_X}, {AX_Z, AX_X, AX_Y}, {AX_Z, AX_Y, AX_X},
        {AX_Y, AX_X, AX_Y}, {AX_Z, AX_X, AX_Z}, {AX_X, AX_Y, AX_X},
        {AX_Z, AX_Y, AX_Z}, {AX_X, AX_Z, AX_X}, {AX_Y, AX_Z, AX_Y}
    };

    // data riding along the polynomial stages
    typedef struct packed {
        logic [30:0] u;
        logic        neg;
        logic [1:0]  k;
    } t_side;

    typedef struct packed {
        logic signed [32:0] w;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [34:0] w;
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [34:0] z;
    } t_qsum;

endpackage

>>> hdl/e2q_horner.sv
// ---------------------------------------------------------------------------
// e2q_horner
// Sine and cosine Horner series side by side, three stages per step.
// ---------------------------------------------------------------------------
module e2q_horner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [30:0]         i_s2,
    input  e2q_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [31:0]         o_ts,
    output logic [31:0]         o_tc,
    output e2q_pkg::t_side      o_side
);

    localparam int ST = e2q_pkg::STEPS;

    logic [ST:0]      w_v;
    logic [30:0]      w_s2   [0:ST];
    e2q_pkg::t_side   w_side [0:ST];
    logic [31:0]      w_t    [0:ST][0:1];

    assign w_v[0]     = i_valid;
    assign w_s2[0]    = i_s2;
    assign w_side[0]  = i_side;
    assign w_t[0][0]  = 32'(e2q_pkg::ONE_Q31);
    assign w_t[0][1]  = 32'(e2q_pkg::ONE_Q31);

    for (genvar g = 0; g < ST; g++) begin : g_step
        localparam logic [7:0]  D_S = 8'(e2q_pkg::SIN_DEN[g]);
        localparam logic [7:0]  D_C = 8'(e2q_pkg::COS_DEN[g]);
        // floor(2^34/d): quotient estimate is low by at most one
        localparam logic [33:0] M_S = 34'((64'd1 << 34) / 64'(e2q_pkg::SIN_DEN[g]));
        localparam logic [33:0] M_C = 34'((64'd1 << 34) / 64'(e2q_pkg::COS_DEN[g]));
        localparam logic [7:0]  DEN [2] = '{D_S, D_C};
        localparam logic [33:0] RCP [2] = '{M_S, M_C};

        logic [2:0]     r_v;
        logic [30:0]    r_s2   [3];
        e2q_pkg::t_side r_side [3];
        logic [62:0]    r_p    [2];
        logic [31:0]    r_n    [2];
        logic [31:0]    r_q0   [2];
        logic [31:0]    r_t    [2];
        logic [31:0]    n_n    [2];
        logic [31:0]    n_q0   [2];
        logic [31:0]    n_t    [2];
        logic [39:0]    w_rem  [2];

        always_comb begin
            for (int c = 0; c < 2; c++) begin
                n_n[c]   = 32'((64'(r_p[c]) + (64'(DEN[c]) << 30)) >> 31);
                n_q0[c]  = 32'((66'(n_n[c]) * 66'(RCP[c])) >> 34);
                w_rem[c] = 40'(r_n[c]) - 40'(r_q0[c]) * 40'(DEN[c]);
                n_t[c]   = 32'(e2q_pkg::ONE_Q31 - 33'(r_q0[c])
                               - 33'(w_rem[c] >= 40'(DEN[c])));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= '0;
            end else begin
                r_v <= {r_v[1:0], w_v[g]};
            end
        end

        always_ff @(posedge i_clk) begin
            r_s2[0]   <= w_s2[g];
            r_s2[1]   <= r_s2[0];
            r_s2[2]   <= r_s2[1];
            r_side[0] <= w_side[g];
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            for (int c = 0; c < 2; c++) begin
                r_p[c]  <= 63'(w_s2[g]) * 63'(w_t[g][c]);
                r_n[c]  <= n_n[c];
                r_q0[c] <= n_q0[c];
                r_t[c]  <= n_t[c];
            end
        end

        assign w_v[g+1]     = r_v[2];
        assign w_s2[g+1]    = r_s2[2];
        assign w_side[g+1]  = r_side[2];
        assign w_t[g+1][0]  = r_t[0];
        assign w_t[g+1][1]  = r_t[1];
    end

    assign o_valid = w_v[ST];
    assign o_ts    = w_t[ST][0];
    assign o_tc    = w_t[ST][1];
    assign o_side  = w_side[ST];

endmodule

>>> hdl/e2q_sincos.sv
// ---------------------------------------------------------------------------
// e2q_sincos
// Half-angle sine and cosine: quadrant reduction, series, quadrant fix-up.
// ---------------------------------------------------------------------------
module e2q_sincos (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    output logic signed [32:0] o_sin,
    output logic signed [32:0] o_cos
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [63:0] w_r [0:4];
    logic [1:0]         w_k [0:4];
    logic [4:0]         w_v;

    // raw angle in 2^-29 units is the half angle; move it to 2^-60
    assign w_r[0] = 64'(i_angle) <<< 31;
    assign w_k[0] = QUAD_0;
    assign w_v[0] = i_valid;

    for (genvar i = 0; i < 4; i++) begin : g_red
        logic signed [63:0] n_r;
        logic [1:0]         n_k;
        logic signed [63:0] r_r;
        logic [1:0]         r_k;
        logic               r_v;

        always_comb begin
            n_r = w_r[i];
            n_k = w_k[i];
            if (w_r[i] > e2q_pkg::RED_E) begin
                n_r = w_r[i] - e2q_pkg::RED_P;
                n_k = w_k[i] + 2'd1;
            end else if (w_r[i] < -e2q_pkg::RED_E) begin
                n_r = w_r[i] + e2q_pkg::RED_P;
                n_k = w_k[i] - 2'd1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_r <= n_r;
            r_k <= n_k;
        end

        assign w_r[i+1] = r_r;
        assign w_k[i+1] = r_k;
        assign w_v[i+1] = r_v;
    end

    logic        r_v_mag, r_v_u, r_v_s2, r_v_sm, r_v_q;
    logic [59:0] r_mag;
    logic        r_neg_mag, r_neg_u;
    logic [1:0]  r_k_mag, r_k_u;
    logic [30:0] r_u;
    logic [30:0] r_s2;
    e2q_pkg::t_side r_side;

    logic           w_hv;
    logic [31:0]    w_ts, w_tc;
    e2q_pkg::t_side w_hside;

    logic [31:0]    r_sr, r_tc;
    logic           r_neg_sm;
    logic [1:0]     r_k_sm;
    logic signed [32:0] r_sin, r_cos;

    logic signed [32:0] w_sr, w_cr;
    logic signed [32:0] n_sin, n_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mag <= 1'b0;
            r_v_u   <= 1'b0;
            r_v_s2  <= 1'b0;
            r_v_sm  <= 1'b0;
            r_v_q   <= 1'b0;
        end else begin
            r_v_mag <= w_v[4];
            r_v_u   <= r_v_mag;
            r_v_s2  <= r_v_u;
            r_v_sm  <= w_hv;
            r_v_q   <= r_v_sm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_mag <= w_r[4] < 0;
        r_mag     <= 60'((w_r[4] < 0) ? -w_r[4] : w_r[4]);
        r_k_mag   <= w_k[4];

        r_u       <= 31'((61'(r_mag) + (61'd1 << 28)) >> 29);
        r_neg_u   <= r_neg_mag;
        r_k_u     <= r_k_mag;

        r_s2      <= 31'((62'(r_u) * 62'(r_u) + (62'd1 << 30)) >> 31);
        r_side    <= '{u: r_u, neg: r_neg_u, k: r_k_u};

        r_sr      <= 32'((63'(w_hside.u) * 63'(w_ts) + (63'd1 << 30)) >> 31);
        r_tc      <= w_tc;
        r_neg_sm  <= w_hside.neg;
        r_k_sm    <= w_hside.k;

        r_sin     <= n_sin;
        r_cos     <= n_cos;
    end

    e2q_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_s2),
        .i_s2    (r_s2),
        .i_side  (r_side),
        .o_valid (w_hv),
        .o_ts    (w_ts),
        .o_tc    (w_tc),
        .o_side  (w_hside)
    );

    always_comb begin
        w_sr = r_neg_sm ? -33'(r_sr) : 33'(r_sr);
        w_cr = 33'(r_tc);
        case (r_k_sm)
            QUAD_0: begin
                n_sin = w_sr;
                n_cos = w_cr;
            end
            QUAD_1: begin
                n_sin = w_cr;
                n_cos = -w_sr;
            end
            QUAD_2: begin
                n_sin = -w_sr;
                n_cos = -w_cr;
            end
            default: begin
                n_sin = -w_cr;
                n_cos = w_sr;
            end
        endcase
    end

    assign o_valid = r_v_q;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

>>> hdl/e2q_qmul.sv
// ---------------------------------------------------------------------------
// e2q_qmul
// Hamilton product: rounded partial products, then four-term sums.
// ---------------------------------------------------------------------------
module e2q_qmul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  e2q_pkg::t_quat i_p,
    input  e2q_pkg::t_quat i_q,
    output logic           o_valid,
    output e2q_pkg::t_qsum o_r
);

    logic signed [32:0] w_a [4];
    logic signed [32:0] w_b [4];
    logic signed [65:0] w_prod [4][4];
    logic signed [32:0] r_pr [4][4];
    logic [1:0]         r_v;
    e2q_pkg::t_qsum     r_sum, n_sum;

    assign w_a[0] = i_p.w;
    assign w_a[1] = i_p.x;
    assign w_a[2] = i_p.y;
    assign w_a[3] = i_p.z;
    assign w_b[0] = i_q.w;
    assign w_b[1] = i_q.x;
    assign w_b[2] = i_q.y;
    assign w_b[3] = i_q.z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_prod[i][j] = 66'(w_a[i]) * 66'(w_b[j]);
            end
        end
    end

    always_comb begin
        n_sum.w = 35'(r_pr[0][0]) - 35'(r_pr[1][1]) - 35'(r_pr[2][2]) - 35'(r_pr[3][3]);
        n_sum.x = 35'(r_pr[0][1]) + 35'(r_pr[1][0]) + 35'(r_pr[2][3]) - 35'(r_pr[3][2]);
        n_sum.y = 35'(r_pr[0][2]) - 35'(r_pr[1][3]) + 35'(r_pr[2][0]) + 35'(r_pr[3][1]);
        n_sum.z = 35'(r_pr[0][3]) + 35'(r_pr[1][2]) - 35'(r_pr[2][1]) + 35'(r_pr[3][0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                // round half up to Q.31
                r_pr[i][j] <= 33'((w_prod[i][j] + 66'sd1073741824) >>> 31);
            end
        end
        r_sum <= n_sum;
    end

    assign o_valid = r_v[1];
    assign o_r     = r_sum;

endmodule

>>> hdl/euler_to_quaternion.sv
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Three Euler angles and an axis sequence code in, unit quaternion out.
// ---------------------------------------------------------------------------
// Fully pipelined: one item is taken every cycle and busy never rises. Each
// result appears on a single-cycle o_done strobe; there is no backpressure,
// so the receiver must take it in that cycle. The latency is set by the
// sine/cosine units (quadrant reduction plus six series steps of three
// stages each), two quaternion product units that each register rounded
// partial products and then their sums, and the output rounding register.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_angle_first,
    input  logic signed [31:0] i_angle_second,
    input  logic signed [31:0] i_angle_third,
    input  logic [4:0]         i_sequence_req,
    output logic               o_done,
    output logic signed [31:0] o_quat_w,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z
);

    localparam int SCL = e2q_pkg::SC_LAT;
    localparam int QML = e2q_pkg::QM_LAT;

    logic [2:0]         w_sc_vld;
    logic signed [32:0] w_sin [3];
    logic signed [32:0] w_cos [3];
    logic signed [31:0] w_ang [3];

    logic [SCL-1:0]     r_vld_pipe;
    logic [4:0]         r_code_pipe [SCL];

    assign busy     = 1'b0;
    assign w_ang[0] = i_angle_first;
    assign w_ang[1] = i_angle_second;
    assign w_ang[2] = i_angle_third;

    for (genvar i = 0; i < 3; i++) begin : g_sc
        e2q_sincos u_sincos (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (start & ~busy),
            .i_angle (w_ang[i]),
            .o_valid (w_sc_vld[i]),
            .o_sin   (w_sin[i]),
            .o_cos   (w_cos[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[SCL-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_pipe[0] <= i_sequence_req;
        for (int i = 1; i < SCL; i++) begin
            r_code_pipe[i] <= r_code_pipe[i-1];
        end
    end

    // build the three axis quaternions for the code leaving the sincos units
    logic [4:0]     w_code;
    logic           w_code_ok;
    logic           w_ext;
    logic [5:0]     w_axes;
    logic [1:0]     w_ax [3];
    e2q_pkg::t_quat w_q [3];
    e2q_pkg::t_quat w_first, w_third;

    assign w_code    = r_code_pipe[SCL-1];
    assign w_code_ok = w_code <= e2q_pkg::SEQ_LAST;
    assign w_ext     = w_code >= e2q_pkg::SEQ_EXT_FIRST;
    assign w_axes    = w_code_ok ? e2q_pkg::SEQ_AXES[w_code] : '0;
    assign w_ax[0]   = w_axes[5:4];
    assign w_ax[1]   = w_axes[3:2];
    assign w_ax[2]   = w_axes[1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i].w = w_cos[i];
            w_q[i].x = (w_ax[i] == e2q_pkg::AX_X) ? w_sin[i] : '0;
            w_q[i].y = (w_ax[i] == e2q_pkg::AX_Y) ? w_sin[i] : '0;
            w_q[i].z = (w_ax[i] == e2q_pkg::AX_Z) ? w_sin[i] : '0;
        end
    end

    // extrinsic sequences multiply in reverse angle order
    assign w_first = w_ext ? w_q[2] : w_q[0];
    assign w_third = w_ext ? w_q[0] : w_q[2];

    logic           w_qm1_vld, w_qm2_vld;
    e2q_pkg::t_qsum w_tmp, w_res;
    e2q_pkg::t_quat w_tmp_q;
    e2q_pkg::t_quat r_third [QML];
    logic           r_ok [2*QML];

    e2q_qmul u_qmul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sc_vld[0]),
        .i_p     (w_first),
        .i_q     (w_q[1]),
        .o_valid (w_qm1_vld),
        .o_r     (w_tmp)
    );

    always_ff @(posedge i_clk) begin
        r_third[0] <= w_third;
        for (int i = 1; i < QML; i++) begin
            r_third[i] <= r_third[i-1];
        end
        r_ok[0] <= w_code_ok;
        for (int i = 1; i < 2 * QML; i++) begin
            r_ok[i] <= r_ok[i-1];
        end
    end

    // product of two axis rotations has norm ~1, so each part fits 33 bits
    assign w_tmp_q.w = 33'(w_tmp.w);
    assign w_tmp_q.x = 33'(w_tmp.x);
    assign w_tmp_q.y = 33'(w_tmp.y);
    assign w_tmp_q.z = 33'(w_tmp.z);

    e2q_qmul u_qmul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qm1_vld),
        .i_p     (w_tmp_q),
        .i_q     (r_third[QML-1]),
        .o_valid (w_qm2_vld),
        .o_r     (w_res)
    );

    function automatic logic signed [31:0] to_q30(input logic signed [34:0] v);
        logic signed [34:0] r;
        r = (v + 35'sd1) >>> 1;
        if (r > 35'sd1073741824) begin
            r = 35'sd1073741824;
        end else if (r < -35'sd1073741824) begin
            r = -35'sd1073741824;
        end
        return 32'(r);
    endfunction

    logic               r_done;
    logic signed [31:0] r_quat_w, r_quat_x, r_quat_y, r_quat_z;
    logic               w_ok_out;

    assign w_ok_out = r_ok[2*QML-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_qm2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat_w <= w_ok_out ? to_q30(w_res.w) : '0;
        r_quat_x <= w_ok_out ? to_q30(w_res.x) : '0;
        r_quat_y <= w_ok_out ? to_q30(w_res.y) : '0;
        r_quat_z <= w_ok_out ? to_q30(w_res.z) : '0;
    end

    assign o_done   = r_done;
    assign o_quat_w = r_quat_w;
    assign o_quat_x = r_quat_x;
    assign o_quat_y = r_quat_y;
    assign o_quat_z = r_quat_z;

    logic w_in_range;
    assign w_in_range = (o_quat_w <= 32'sd1073741824) && (o_quat_w >= -32'sd1073741824)
                     && (o_quat_x <= 32'sd1073741824) && (o_quat_x >= -32'sd1073741824)
                     && (o_quat_y <= 32'sd1073741824) && (o_quat_y >= -32'sd1073741824)
                     && (o_quat_z <= 32'sd1073741824) && (o_quat_z >= -32'sd1073741824);

    logic w_sc_in_step;
    assign w_sc_in_step = (w_sc_vld[0] == w_sc_vld[1]) && (w_sc_vld[0] == w_sc_vld[2])
                       && (w_sc_vld[0] == r_vld_pipe[SCL-1]);

    `E2Q_CHECK(a_sc_lockstep, w_sc_in_step, "sincos units out of step with code line")
    `E2Q_CHECK_NEXT(a_done_follows, w_qm2_vld, o_done, "product valid did not reach o_done")
    `E2Q_CHECK(a_out_range, !o_done || w_in_range, "result outside unit range")

endmodule

>>> tb/sv/tb_euler_to_quaternion.sv
// ---------------------------------------------------------------------------
// tb_euler_to_quaternion
// Drives angle triples and sequence codes into the pipeline, predicts each
// quaternion with a bit-exact fixed point model and checks every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

class quat_scoreboard;
    logic signed [31:0] exp_w[$], exp_x[$], exp_y[$], exp_z[$];
    int errors = 0;

    static function longint round_mul(longint a, longint b);
        longint p;
        p = a * b + 64'sd1073741824;
        return p >>> 31;
    endfunction

    static function longint horner_eval(longint s2, bit is_sin);
        longint t, d;
        int i;
        int sden[6] = '{156, 110, 72, 42, 20, 6};
        int cden[6] = '{132, 90, 56, 30, 12, 2};
        t = 64'sd2147483648;
        for (i = 0; i < 6; i++) begin
            d = is_sin ? sden[i] : cden[i];
            t = 64'sd2147483648 - (s2 * t + (d <<< 30)) / (d <<< 31);
        end
        return t;
    endfunction

    static task half_sincos(input logic signed [31:0] a, output longint s,
                            output longint c);
        longint r, mag, u, s2, sr, cr;
        int k, i;
        bit neg;
        r = longint'(a) <<< 31;
        k = 0;
        for (i = 0; i < 4; i++) begin
            if (r > e2q_pkg::RED_E) begin
                r -= e2q_pkg::RED_P; k++;
            end else if (r < -e2q_pkg::RED_E) begin
                r += e2q_pkg::RED_P; k--;
            end
        end
        neg = r < 0;
        mag = neg ? -r : r;
        u = (mag + (64'sd1 <<< 28)) >>> 29;
        s2 = (u * u + (64'sd1 <<< 30)) >>> 31;
        sr = (u * horner_eval(s2, 1) + (64'sd1 <<< 30)) >>> 31;
        cr = horner_eval(s2, 0);
        if (neg) sr = -sr;
        case ((k + 4) & 3)
            0: begin s = sr;  c = cr;  end
            1: begin s = cr;  c = -sr; end
            2: begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr; end
        endcase
    endtask

    static task hamilton(input longint p[4], input longint q[4], output longint o[4]);
        o[0] = round_mul(p[0],q[0]) - round_mul(p[1],q[1]) - round_mul(p[2],q[2])
             - round_mul(p[3],q[3]);
        o[1] = round_mul(p[0],q[1]) + round_mul(p[1],q[0]) + round_mul(p[2],q[3])
             - round_mul(p[3],q[2]);
        o[2] = round_mul(p[0],q[2]) - round_mul(p[1],q[3]) + round_mul(p[2],q[0])
             + round_mul(p[3],q[1]);
        o[3] = round_mul(p[0],q[3]) + round_mul(p[1],q[2]) - round_mul(p[2],q[1])
             + round_mul(p[3],q[0]);
    endtask

    static function logic signed [31:0] to_q30(longint v);
        longint r;
        r = (v + 1) >>> 1;
        if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
        if (r < -(64'sd1 <<< 30)) r = -(64'sd1 <<< 30);
        return r[31:0];
    endfunction

    task note_item(logic signed [31:0] a0, logic signed [31:0] a1,
                   logic signed [31:0] a2, logic [4:0] code);
        longint q[3][4];
        longint tmp[4], res[4], s, c;
        logic [31:0] ang[3];
        logic [5:0] axes;
        int i;
        ang[0] = a0; ang[1] = a1; ang[2] = a2;
        res = '{0, 0, 0, 0};
        if (code <= e2q_pkg::SEQ_LAST) begin
            axes = e2q_pkg::SEQ_AXES[code];
            for (i = 0; i < 3; i++) begin
                half_sincos(ang[i], s, c);
                q[i] = '{c, 0, 0, 0};
                q[i][1 + axes[5 - 2*i -: 2]] = s;
            end
            if (code < e2q_pkg::SEQ_EXT_FIRST) begin
                hamilton(q[0], q[1], tmp);
                hamilton(tmp, q[2], res);
            end else begin
                hamilton(q[2], q[1], tmp);
                hamilton(tmp, q[0], res);
            end
            for (i = 0; i < 4; i++) res[i] = to_q30(res[i]);
        end
        exp_w.push_back(res[0][31:0]); exp_x.push_back(res[1][31:0]);
        exp_y.push_back(res[2][31:0]); exp_z.push_back(res[3][31:0]);
    endtask

    task check_result(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [31:0] ew, ex, ey, ez;
        if (exp_w.size() == 0) begin
            $display("%0t: unexpected result w=%h x=%h y=%h z=%h", $time, w, x, y, z);
            errors++;
            return;
        end
        ew = exp_w.pop_front(); ex = exp_x.pop_front();
        ey = exp_y.pop_front(); ez = exp_z.pop_front();
        if (w !== ew) begin $display("%0t: w expected %h got %h", $time, ew, w); errors++; end
        if (x !== ex) begin $display("%0t: x expected %h got %h", $time, ex, x); errors++; end
        if (y !== ey) begin $display("%0t: y expected %h got %h", $time, ey, y); errors++; end
        if (z !== ez) begin $display("%0t: z expected %h got %h", $time, ez, z); errors++; end
    endtask
endclass

module tb_euler_to_quaternion;
    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic busy, o_done;
    logic signed [31:0] i_angle_first = 0, i_angle_second = 0, i_angle_third = 0;
    logic [4:0] i_sequence_req = 0;
    logic signed [31:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    quat_scoreboard sb = new();
    int cycles = 0;
    bit calm = 0;

    always #5 i_clk = ~i_clk;

    euler_to_quaternion dut (.*);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && start && !busy)
            sb.note_item(i_angle_first, i_angle_second, i_angle_third, i_sequence_req);
        if (i_rst_n && o_done)
            sb.check_result(o_quat_w, o_quat_x, o_quat_y, o_quat_z);
    end

    function logic [31:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 15) - 8;
            3: return 32'sd421657428 + $urandom_range(0, 64) - 32; // near pi/2
            default: return $urandom();
        endcase
    endfunction

    // hold the item until accepted; start stays high into the next item
    task send_item(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2, logic [4:0] code);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_angle_first <= a0; i_angle_second <= a1; i_angle_third <= a2;
        i_sequence_req <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        int i, idle;
        logic [31:0] ext[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (i = 0; i < 32; i++)
            send_item(ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4], i[4:0]);
        for (i = 0; i < 450; i++) begin
            if (i > 380) calm = 1;
            send_item(pick_angle(), pick_angle(), pick_angle(),
                      ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                  : 5'($urandom_range(0, 23)));
        end
        start <= 0;
        idle = 0;
        while (sb.exp_w.size() != 0 && idle < 1000) begin
            @(posedge i_clk);
            idle++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_w.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
